/* rtl/core/afc_pkg.sv */
// ----------------------------------------------------------------------------
// afc_pkg
// Shared widths, plane table and result codes for the box/frustum cull test.
// ----------------------------------------------------------------------------
package afc_pkg;

  // Coordinate format: signed fixed point, three coordinates per corner
  localparam int COORD_WIDTH = 16;
  localparam int HALF_WIDTH  = COORD_WIDTH - 1;
  localparam int CORNER_W    = 3 * COORD_WIDTH;

  // Exact intermediate widths
  localparam int DIFF_W = COORD_WIDTH + 1;       // corner or centre difference
  localparam int PROD_W = 2 * DIFF_W;            // u*v partial product
  localparam int NORM_W = PROD_W + 1;            // normal component
  localparam int MAG_W  = NORM_W - 1;            // |normal component|
  localparam int DOT_W  = NORM_W + DIFF_W;       // n * (centre - anchor)
  localparam int HPRD_W = HALF_WIDTH + MAG_W;    // half * |n|
  localparam int ACC_W  = DOT_W + 3;             // sum of three terms

  localparam int CORNERS = 8;
  localparam int PLANES  = 6;
  localparam int IDX_W   = 4;
  localparam int PLANE_W = 3;

  localparam logic [PLANE_W-1:0] PLANE_NONE = 3'd6;

  // Per plane: corner a, corner b, base corner, anchor corner.
  // Normal = (a - base) x (b - base). Order: back, front, left, right, bottom, top.
  localparam logic [2:0] PLANE_TAB [PLANES][4] = '{
    '{3'd7, 3'd5, 3'd4, 3'd4},
    '{3'd1, 3'd3, 3'd0, 3'd0},
    '{3'd4, 3'd1, 3'd0, 3'd1},
    '{3'd2, 3'd7, 3'd3, 3'd2},
    '{3'd3, 3'd7, 3'd0, 3'd3},
    '{3'd6, 3'd2, 3'd1, 3'd2}
  };

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [NORM_W-1:0]      norm_t;
  typedef logic signed [DOT_W-1:0]       dot_t;
  typedef logic        [HPRD_W-1:0]      hprd_t;
  typedef logic signed [ACC_W-1:0]       acc_t;

  // Pull one axis out of a packed corner register
  function automatic coord_t corner_coord(input logic [CORNER_W-1:0] r, input int axis);
    return r[axis*COORD_WIDTH +: COORD_WIDTH];
  endfunction

endpackage

/* rtl/core/aabb_frustum_cull_test.sv */
// Throughput: one box per cycle; the seven-stage datapath (differences, cross
// products, normals, dot products, partial sums, compare, priority) advances
// as a whole and holds while a result is stalled at the output.
// Reset: synchronous; clears valid bits and all eight corners, so every box is
// culled by the back plane until corners are written.
// ----------------------------------------------------------------------------
// aabb_frustum_cull_test
// Pipelined test of one axis-aligned box against six frustum planes built
// from eight corner registers; reports visibility and first culling plane.
// ----------------------------------------------------------------------------
module aabb_frustum_cull_test
  import afc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // configuration write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [IDX_W-1:0]       cfg_index,
  input  logic [CORNER_W-1:0]    cfg_data,
  // box input
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [COORD_WIDTH-1:0] center_x,
  input  logic signed [COORD_WIDTH-1:0] center_y,
  input  logic signed [COORD_WIDTH-1:0] center_z,
  input  logic [HALF_WIDTH-1:0]  half_x,
  input  logic [HALF_WIDTH-1:0]  half_y,
  input  logic [HALF_WIDTH-1:0]  half_z,
  // result output
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   visible,
  output logic [PLANE_W-1:0]     culling_plane
);

  logic [CORNER_W-1:0] corners [CORNERS];

  logic adv;
  logic v1, v2, v3, v4, v5, v6;

  diff_t du [PLANES][3];
  diff_t dv [PLANES][3];
  diff_t dq1 [PLANES][3];
  diff_t dq2 [PLANES][3];
  diff_t dq3 [PLANES][3];
  logic [HALF_WIDTH-1:0] h1 [3];
  logic [HALF_WIDTH-1:0] h2 [3];
  logic [HALF_WIDTH-1:0] h3 [3];
  prod_t pa [PLANES][3];
  prod_t pb [PLANES][3];
  norm_t nrm [PLANES][3];
  dot_t  dot [PLANES][3];
  hprd_t hp  [PLANES][3];
  acc_t  sdot [PLANES];
  acc_t  shp  [PLANES];
  logic [PLANES-1:0] cull;

  coord_t cen [3];
  logic [HALF_WIDTH-1:0] hin [3];

  assign cen[0] = center_x;
  assign cen[1] = center_y;
  assign cen[2] = center_z;
  assign hin[0] = half_x;
  assign hin[1] = half_y;
  assign hin[2] = half_z;

  // Whole pipeline moves unless a result is held at the output
  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  // Corner registers; out-of-range indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CORNERS; c++) corners[c] <= '0;
    end else if (cfg_valid && cfg_ready && (cfg_index < IDX_W'(CORNERS))) begin
      corners[cfg_index[2:0]] <= cfg_data;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
      v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid; v2 <= v1; v3 <= v2;
      v4 <= v3; v5 <= v4; v6 <= v5;
      out_valid <= v6;
    end
  end

  // Datapath stages
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int p = 0; p < PLANES; p++) begin
        for (int i = 0; i < 3; i++) begin
          // stage 1: edge vectors and centre minus anchor
          du[p][i]  <= DIFF_W'(corner_coord(corners[PLANE_TAB[p][0]], i))
                     - DIFF_W'(corner_coord(corners[PLANE_TAB[p][2]], i));
          dv[p][i]  <= DIFF_W'(corner_coord(corners[PLANE_TAB[p][1]], i))
                     - DIFF_W'(corner_coord(corners[PLANE_TAB[p][2]], i));
          dq1[p][i] <= DIFF_W'(cen[i])
                     - DIFF_W'(corner_coord(corners[PLANE_TAB[p][3]], i));
          dq2[p][i] <= dq1[p][i];
          dq3[p][i] <= dq2[p][i];
          // stage 4: dot term and extent term
          dot[p][i] <= DOT_W'(nrm[p][i]) * DOT_W'(dq3[p][i]);
          hp[p][i]  <= HPRD_W'(h3[i]) * HPRD_W'(nrm[p][i][NORM_W-1] ?
                         MAG_W'(-nrm[p][i]) : MAG_W'(nrm[p][i]));
        end
        // stage 2: cross-product partial products
        pa[p][0] <= PROD_W'(du[p][1]) * PROD_W'(dv[p][2]);
        pb[p][0] <= PROD_W'(du[p][2]) * PROD_W'(dv[p][1]);
        pa[p][1] <= PROD_W'(du[p][2]) * PROD_W'(dv[p][0]);
        pb[p][1] <= PROD_W'(du[p][0]) * PROD_W'(dv[p][2]);
        pa[p][2] <= PROD_W'(du[p][0]) * PROD_W'(dv[p][1]);
        pb[p][2] <= PROD_W'(du[p][1]) * PROD_W'(dv[p][0]);
        // stage 3: normal components
        for (int i = 0; i < 3; i++) begin
          nrm[p][i] <= NORM_W'(pa[p][i]) - NORM_W'(pb[p][i]);
        end
        // stage 5: partial sums
        sdot[p] <= ACC_W'(dot[p][0]) + ACC_W'(dot[p][1]) + ACC_W'(dot[p][2]);
        shp[p]  <= acc_t'({3'b000, hp[p][0]}) + acc_t'({3'b000, hp[p][1]})
                 + acc_t'({3'b000, hp[p][2]});
        // stage 6: plane compare
        cull[p] <= (sdot[p] >= shp[p]);
      end
      for (int i = 0; i < 3; i++) begin
        h1[i] <= hin[i];
        h2[i] <= h1[i];
        h3[i] <= h2[i];
      end
    end
  end

  // Stage 7: first culling plane
  logic [PLANE_W-1:0] plane_next;
  always_comb begin
    plane_next = PLANE_NONE;
    for (int p = PLANES - 1; p >= 0; p--) begin
      if (cull[p]) plane_next = PLANE_W'(p);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      culling_plane <= plane_next;
      visible       <= (cull == '0);
    end
  end

  // Checks
  a_vis_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (visible == (culling_plane == PLANE_NONE)))
    else $error("visible disagrees with culling_plane");
  a_plane_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (culling_plane <= PLANE_NONE))
    else $error("culling_plane out of range");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(culling_plane)))
    else $error("stalled result lost");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    (v6 && !in_stall) |=> out_valid)
    else $error("pipeline dropped an item");

endmodule

/* bench/tb_aabb_frustum_cull_test.sv */
// ----------------------------------------------------------------------------
// tb_aabb_frustum_cull_test
// Streams boxes through the cull test under several frustum settings and
// random handshake pressure. Every result is checked against an exact
// integer plane test computed in the bench.
// ----------------------------------------------------------------------------
module tb_aabb_frustum_cull_test;
  import afc_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 20;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] cx, cy, cz;
    logic [HALF_WIDTH-1:0]         hx, hy, hz;
  } box_t;

  typedef struct packed {
    logic               vis;
    logic [PLANE_W-1:0] plane;
  } verdict_t;

  // Directed row: box plus an optional hand-typed verdict
  typedef struct {
    box_t     box;
    logic     known;
    verdict_t want;
  } box_row_t;

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [IDX_W-1:0] cfg_index;
  logic [CORNER_W-1:0] cfg_data;
  logic in_valid, in_stall;
  logic signed [COORD_WIDTH-1:0] center_x, center_y, center_z;
  logic [HALF_WIDTH-1:0] half_x, half_y, half_z;
  logic out_valid, out_stall;
  logic visible;
  logic [PLANE_W-1:0] culling_plane;

  aabb_frustum_cull_test i_dut (.*);

  // Bench copy of the corner registers
  logic [CORNER_W-1:0] corner_shadow [CORNERS];
  verdict_t pending_verdicts[$];
  int  errors;
  int  idle_pct_in, stall_pct_out;
  int  hold_cycles;
  int  quiet_cycles;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint corner_axis(int c, int axis);
    logic signed [COORD_WIDTH-1:0] v;
    v = corner_shadow[c][axis*COORD_WIDTH +: COORD_WIDTH];
    return longint'(v);
  endfunction

  // Exact plane test: n.(centre - anchor) >= sum half*|n|
  function automatic logic plane_rejects(int p, box_t b);
    longint u[3], v[3], n[3], cen[3], hf[3];
    logic signed [127:0] acc, nn, dd;
    longint base, an;
    cen[0] = b.cx; cen[1] = b.cy; cen[2] = b.cz;
    hf[0] = b.hx; hf[1] = b.hy; hf[2] = b.hz;
    for (int i = 0; i < 3; i++) begin
      base = corner_axis(PLANE_TAB[p][2], i);
      u[i] = corner_axis(PLANE_TAB[p][0], i) - base;
      v[i] = corner_axis(PLANE_TAB[p][1], i) - base;
    end
    n[0] = u[1]*v[2] - u[2]*v[1];
    n[1] = u[2]*v[0] - u[0]*v[2];
    n[2] = u[0]*v[1] - u[1]*v[0];
    acc = 0;
    for (int i = 0; i < 3; i++) begin
      an = corner_axis(PLANE_TAB[p][3], i);
      nn = n[i];
      dd = cen[i] - an;
      acc = acc + nn * dd;
      nn = (n[i] < 0) ? -n[i] : n[i];
      dd = hf[i];
      acc = acc - nn * dd;
    end
    return acc >= 0;
  endfunction

  function automatic verdict_t classify_box(box_t b);
    verdict_t r;
    r.vis = 1'b1;
    r.plane = PLANE_NONE;
    for (int p = 0; p < PLANES; p++) begin
      if (plane_rejects(p, b)) begin
        r.vis = 1'b0;
        r.plane = PLANE_W'(p);
        break;
      end
    end
    return r;
  endfunction

  function automatic logic [CORNER_W-1:0] pack_corner(int x, int y, int z);
    logic [COORD_WIDTH-1:0] a, bb, c;
    a = COORD_WIDTH'(x); bb = COORD_WIDTH'(y); c = COORD_WIDTH'(z);
    return {c, bb, a};
  endfunction

  // Configuration write; bench shadow updated on the transaction
  task automatic write_corner(int idx, logic [CORNER_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= IDX_W'(idx);
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx < CORNERS) corner_shadow[idx] = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Entered at the falling edge right after the last box transaction
  task automatic wait_empty();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Frustum roughly symmetric about the origin, scale s, depth near/far
  task automatic load_frustum(int s, int zn, int zf);
    int sf;
    sf = 3 * s;
    write_corner(0, pack_corner(-s, -s, zn));
    write_corner(1, pack_corner(-s,  s, zn));
    write_corner(2, pack_corner( s,  s, zn));
    write_corner(3, pack_corner( s, -s, zn));
    write_corner(4, pack_corner(-sf, -sf, zf));
    write_corner(5, pack_corner(-sf,  sf, zf));
    write_corner(6, pack_corner( sf,  sf, zf));
    write_corner(7, pack_corner( sf, -sf, zf));
  endtask

  task automatic load_random_corners();
    for (int i = 0; i < CORNERS; i++)
      write_corner(i, CORNER_W'({$urandom, $urandom}));
  endtask

  // Send one box, holding it while stalled; ends on a falling edge with
  // valid still high so the next box can follow with no gap
  task automatic send_box(box_t b);
    if (clk) @(negedge clk);
    while ($urandom_range(99) < idle_pct_in) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    {center_x, center_y, center_z, half_x, half_y, half_z} <= b;
    do @(posedge clk); while (in_stall);
    pending_verdicts.push_back(classify_box(b));
    @(negedge clk);
  endtask

  function automatic box_t random_box(int span);
    box_t b;
    logic [95:0] raw;
    if ($urandom_range(9) == 0) begin
      raw = {$urandom, $urandom, $urandom};
      b = raw[$bits(box_t)-1:0];
    end else begin
      b.cx = COORD_WIDTH'($signed($urandom_range(2*span)) - span);
      b.cy = COORD_WIDTH'($signed($urandom_range(2*span)) - span);
      b.cz = COORD_WIDTH'($urandom_range(span));
      b.hx = HALF_WIDTH'($urandom_range(span / 4));
      b.hy = HALF_WIDTH'($urandom_range(span / 4));
      b.hz = HALF_WIDTH'($urandom_range(span / 4));
    end
    return b;
  endfunction

  task automatic random_phase(int count, int span, int ipct, int spct);
    idle_pct_in = ipct;
    stall_pct_out = spct;
    repeat (count) send_box(random_box(span));
  endtask

  // Receiver: random stalls, plus an optional long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct_out);
    end
  end

  // Result checker
  always @(posedge clk) begin
    verdict_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        want = pending_verdicts.pop_front();
        if (visible !== want.vis) begin
          $error("visible: expected %0d actual %0d", want.vis, visible);
          errors++;
        end
        if (culling_plane !== want.plane) begin
          $error("culling_plane: expected %0d actual %0d", want.plane, culling_plane);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no transaction
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready) || hold_cycles > 0) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("aabb_frustum_cull_test regression: fail");
        $finish;
      end
    end
  end

  initial begin
    box_row_t rows[$];
    box_row_t r;
    errors = 0;
    idle_pct_in = 0;
    stall_pct_out = 0;
    hold_cycles = 0;
    for (int i = 0; i < CORNERS; i++) corner_shadow[i] = '0;
    rst = 1'b1;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0;
    {center_x, center_y, center_z, half_x, half_y, half_z} = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // After reset every corner is zero: back plane is degenerate, culls all
    r.known = 1'b1; r.want = '{1'b0, 3'd0};
    r.box = '0;                                          rows.push_back(r);
    r.box = {16'sh7fff, 16'sh7fff, 16'sh7fff, 15'h7fff, 15'h7fff, 15'h7fff};
    rows.push_back(r);
    r.box = {16'sh8000, 16'sh8000, 16'sh8000, 15'h0, 15'h0, 15'h0};
    rows.push_back(r);
    foreach (rows[i]) begin
      send_box(rows[i].box);
      if (rows[i].known && classify_box(rows[i].box) !== rows[i].want) begin
        $error("directed row %0d: table verdict disagrees", i);
        errors++;
      end
    end
    wait_empty();

    // Normal frustum; directed boxes inside, outside each side, extremes
    load_frustum(256, 256, 2048);
    rows.delete();
    r.known = 1'b0; r.want = '0;
    r.box = {16'sd0, 16'sd0, 16'sd1024, 15'd16, 15'd16, 15'd16};    rows.push_back(r);
    r.box = {16'sd0, 16'sd0, 16'sd0, 15'd16, 15'd16, 15'd16};       rows.push_back(r);
    r.box = {16'sd0, 16'sd0, 16'sd4000, 15'd16, 15'd16, 15'd16};    rows.push_back(r);
    r.box = {-16'sd9000, 16'sd0, 16'sd1024, 15'd16, 15'd16, 15'd16}; rows.push_back(r);
    r.box = {16'sd9000, 16'sd0, 16'sd1024, 15'd16, 15'd16, 15'd16}; rows.push_back(r);
    r.box = {16'sd0, -16'sd9000, 16'sd1024, 15'd16, 15'd16, 15'd16}; rows.push_back(r);
    r.box = {16'sd0, 16'sd9000, 16'sd1024, 15'd16, 15'd16, 15'd16}; rows.push_back(r);
    r.box = {16'sd0, 16'sd0, 16'sd100, 15'd200, 15'd200, 15'd200};  rows.push_back(r);
    r.box = {16'sh7fff, 16'sh7fff, 16'sh7fff, 15'h7fff, 15'h7fff, 15'h7fff};
    rows.push_back(r);
    r.box = {16'sh8000, 16'sh8000, 16'sh8000, 15'h7fff, 15'h0, 15'h7fff};
    rows.push_back(r);
    r.box = {16'sh8000, 16'sh7fff, 16'sh0, 15'h5555, 15'h2aaa, 15'h0};
    rows.push_back(r);
    foreach (rows[i]) send_box(rows[i].box);
    random_phase(80, 3000, 0, 0);
    wait_empty();

    // Extreme corners: full-range magnitudes exercise the widest products
    write_corner(0, pack_corner(-32768, -32768, -32768));
    write_corner(1, pack_corner(-32768, 32767, -32768));
    write_corner(2, pack_corner(32767, 32767, -32768));
    write_corner(3, pack_corner(32767, -32768, -32768));
    write_corner(4, pack_corner(-32768, -32768, 32767));
    write_corner(5, pack_corner(-32768, 32767, 32767));
    write_corner(6, pack_corner(32767, 32767, 32767));
    write_corner(7, pack_corner(32767, -32768, 32767));
    write_corner(9, '1);   // out-of-range index, ignored
    random_phase(80, 32767, 48, 0);

    // Long receiver hold-off while boxes keep coming
    hold_cycles = 60;
    random_phase(30, 32767, 0, 0);
    wait_empty();

    // Random corners, including degenerate shapes
    load_random_corners();
    random_phase(80, 32767, 0, 48);
    wait_empty();

    load_frustum(64, 32, 800);
    random_phase(100, 1200, 38, 38);
    wait_empty();

    load_frustum(1024, 128, 8000);
    random_phase(100, 20000, 0, 0);
    wait_empty();

    if (errors == 0 && pending_verdicts.size() == 0) begin
      $display("aabb_frustum_cull_test regression: pass");
    end else begin
      $display("aabb_frustum_cull_test regression: fail");
    end
    $finish;
  end

endmodule
